// ===== rtl/core/x86_page_table_walker_macros.svh =====
// Assertion macros used by the page-table walker step module.
`ifndef X86_PAGE_TABLE_WALKER_MACROS_SVH
`define X86_PAGE_TABLE_WALKER_MACROS_SVH

`ifndef SYNTHESIS

`define PTW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("page walker check failed");

`define PTW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page walker check failed");

`define PTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page walker check failed");

`else

`define PTW_ASSERT(lbl, clk, rst_n, prop)
`define PTW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ptw_pkg.sv =====
// Types and constants of the page-table walker.
package ptw_pkg;

    localparam int VA_W     = 48;
    localparam int PA_W     = 52;
    localparam int ENTRY_W  = 64;
    localparam int PAB_W    = 6;
    localparam int IDX_W    = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [PAB_W-1:0] PHYS_BITS_RESET = 6'd36;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHYS_BITS = 1'd1;

    // Action codes of an input item
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_ENTRY   = 1'b1;

    localparam logic [PA_W-1:0] PAE_ROOT_MASK = 52'h0_0000_FFFF_FFE0;
    localparam logic [PA_W-1:0] OFF_4K        = 52'h0_0000_0000_0FFF;
    localparam logic [PA_W-1:0] OFF_2M        = 52'h0_0000_001F_FFFF;
    localparam logic [PA_W-1:0] OFF_1G        = 52'h0_0000_3FFF_FFFF;
    localparam int              LARGE_BIT     = 7;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PAGE_4K = 2'd0,
        PAGE_2M = 2'd1,
        PAGE_1G = 2'd2
    } page_t;

    typedef struct packed {
        logic               action;
        logic               long_mode;
        logic [VA_W-1:0]    vaddr;
        logic [ENTRY_W-1:0] entry_data;
    } req_item_t;

    typedef struct packed {
        kind_t           kind;
        logic [PA_W-1:0] address;
        page_t           page_size;
        logic [1:0]      walk_level;
    } rsp_item_t;

endpackage

// ===== rtl/core/ptw_if.sv =====
// Request and response channel interfaces of the page-table walker.
interface ptw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic                         long_mode;
    logic [ptw_pkg::VA_W-1:0]     vaddr;
    logic [ptw_pkg::ENTRY_W-1:0]  entry_data;

    modport source (output valid, action, long_mode, vaddr, entry_data,
                    input ready);
    modport sink   (input valid, action, long_mode, vaddr, entry_data,
                    output ready);
endinterface

interface ptw_rsp_if;
    logic                     valid;
    logic                     ready;
    ptw_pkg::kind_t           kind;
    logic [ptw_pkg::PA_W-1:0] address;
    ptw_pkg::page_t           page_size;
    logic [1:0]               walk_level;

    modport source (output valid, kind, address, page_size, walk_level, input ready);
    modport sink   (input valid, kind, address, page_size, walk_level, output ready);
endinterface

// ===== rtl/core/ptw_in_stage.sv =====
// Input register stage of the page-table walker.
module ptw_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    ptw_req_if.sink             req,
    input  logic                advance,
    output logic                item_valid,
    output ptw_pkg::req_item_t  item
);

    logic               valid_reg;
    logic               valid_next;
    ptw_pkg::req_item_t item_reg;
    logic               take;

    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.action     <= req.action;
            item_reg.long_mode  <= req.long_mode;
            item_reg.vaddr      <= req.vaddr;
            item_reg.entry_data <= req.entry_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/ptw_step.sv =====
// One walk step: walk state and the address logic for one item.
`include "x86_page_table_walker_macros.svh"

module ptw_step
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  ptw_pkg::req_item_t          item,
    input  logic [ptw_pkg::PA_W-1:0]    root_base,
    input  logic [ptw_pkg::PAB_W-1:0]   phys_bits,
    output ptw_pkg::rsp_item_t          res
);

    logic                       busy_reg;
    logic                       busy_next;
    logic                       mode_reg;
    logic                       mode_next;
    logic [ptw_pkg::VA_W-1:0]   va_reg;
    logic [ptw_pkg::VA_W-1:0]   va_next;
    logic [1:0]                 level_reg;
    logic [1:0]                 level_next;

    logic [ptw_pkg::PA_W-1:0]   pmask;
    logic [ptw_pkg::PA_W-1:0]   entry_base;
    logic [ptw_pkg::PA_W-1:0]   read_base;
    logic [ptw_pkg::IDX_W-1:0]  read_idx;
    logic [1:0]                 read_lvl;
    logic                       do_read;
    logic                       do_fin;
    logic [ptw_pkg::PA_W-1:0]   fin_off;
    ptw_pkg::page_t             fin_size;
    logic                       page_bit;

    // Implemented physical address bits, page offset cleared
    always_comb
    begin
        for (int i = 0; i < ptw_pkg::PA_W; i++)
        begin
            pmask[i] = (i >= 12) && (6'(i) < phys_bits);
        end
    end

    assign entry_base = item.entry_data[ptw_pkg::PA_W-1:0] & pmask;
    assign page_bit   = item.entry_data[ptw_pkg::LARGE_BIT];

    always_comb
    begin
        busy_next  = busy_reg;
        mode_next  = mode_reg;
        va_next    = va_reg;
        level_next = level_reg;
        read_base  = entry_base;
        read_idx   = '0;
        read_lvl   = 2'd0;
        do_read    = 1'b0;
        do_fin     = 1'b0;
        fin_off    = ptw_pkg::OFF_4K;
        fin_size   = ptw_pkg::PAGE_4K;

        res.kind       = ptw_pkg::KIND_ERROR;
        res.address    = '0;
        res.page_size  = ptw_pkg::PAGE_4K;
        res.walk_level = 2'd0;

        if (item.action == ptw_pkg::ACT_REQUEST)
        begin
            if (busy_reg)
            begin
                // drop the walk in progress
                busy_next  = 1'b0;
                level_next = 2'd0;
            end
            else
            begin
                busy_next = 1'b1;
                mode_next = item.long_mode;
                do_read   = 1'b1;
                if (item.long_mode)
                begin
                    va_next   = item.vaddr;
                    read_base = root_base & pmask;
                    read_idx  = item.vaddr[47:39];
                end
                else
                begin
                    va_next   = {16'b0, item.vaddr[31:0]};
                    read_base = root_base & ptw_pkg::PAE_ROOT_MASK;
                    read_idx  = {7'b0, item.vaddr[31:30]};
                end
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                case (level_reg)
                    2'd0:
                    begin
                        do_read  = 1'b1;
                        read_idx = va_reg[38:30];
                        read_lvl = 2'd1;
                    end
                    2'd1:
                    begin
                        if (page_bit)
                        begin
                            do_fin   = 1'b1;
                            fin_off  = ptw_pkg::OFF_1G;
                            fin_size = ptw_pkg::PAGE_1G;
                        end
                        else
                        begin
                            do_read  = 1'b1;
                            read_idx = va_reg[29:21];
                            read_lvl = 2'd2;
                        end
                    end
                    2'd2:
                    begin
                        if (page_bit)
                        begin
                            do_fin   = 1'b1;
                            fin_off  = ptw_pkg::OFF_2M;
                            fin_size = ptw_pkg::PAGE_2M;
                        end
                        else
                        begin
                            do_read  = 1'b1;
                            read_idx = va_reg[20:12];
                            read_lvl = 2'd3;
                        end
                    end
                    default:
                    begin
                        do_fin = 1'b1;
                    end
                endcase
            end
            else
            begin
                case (level_reg)
                    2'd0:
                    begin
                        do_read  = 1'b1;
                        read_idx = va_reg[29:21];
                        read_lvl = 2'd1;
                    end
                    2'd1:
                    begin
                        if (page_bit)
                        begin
                            do_fin   = 1'b1;
                            fin_off  = ptw_pkg::OFF_2M;
                            fin_size = ptw_pkg::PAGE_2M;
                        end
                        else
                        begin
                            do_read  = 1'b1;
                            read_idx = va_reg[20:12];
                            read_lvl = 2'd2;
                        end
                    end
                    default:
                    begin
                        do_fin = 1'b1;
                    end
                endcase
            end
        end

        if (do_read)
        begin
            res.kind       = ptw_pkg::KIND_READ;
            res.address    = read_base + {40'b0, read_idx, 3'b0};
            res.walk_level = read_lvl;
            level_next     = read_lvl;
        end
        else if (do_fin)
        begin
            res.kind      = ptw_pkg::KIND_DONE;
            res.address   = (entry_base & ~fin_off) | ({4'b0, va_reg} & fin_off);
            res.page_size = fin_size;
            busy_next     = 1'b0;
            level_next    = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            mode_reg  <= 1'b0;
            va_reg    <= '0;
            level_reg <= 2'd0;
        end
        else if (fire)
        begin
            busy_reg  <= busy_next;
            mode_reg  <= mode_next;
            va_reg    <= va_next;
            level_reg <= level_next;
        end
    end

    // a read leaves the walk waiting for that level's entry
    `PTW_ASSERT_NEXT(a_rd_wait, clk, rst_n, fire && do_read, busy_reg && level_reg == $past(read_lvl))
    // done and error both end the walk
    `PTW_ASSERT_NEXT(a_end_idles, clk, rst_n, fire && !do_read, !busy_reg)
    // three-level walk never reads a fourth table
    `PTW_ASSERT_IMPL(a_pae_depth, clk, rst_n, fire && !mode_reg && busy_reg, res.walk_level != 2'd3)
    // three-level walk has no 1G pages
    `PTW_ASSERT_IMPL(a_pae_2m, clk, rst_n, fire && !mode_reg && do_fin, fin_size != ptw_pkg::PAGE_1G)

endmodule

// ===== rtl/core/x86_page_table_walker.sv =====
// Top level of the page-table walker: config registers, step logic, result register.
//
//  channel  role   carries
//  -------  -----  ---------------------------------------------------------
//  req      sink   request (virtual address, mode) or returned table entry
//  rsp      source entry read address, translated address, or error
//  cfg_*    write  root_table_base (index 0), phys_addr_bits (index 1)
//
// Each item waits in the input register while the step logic works on it and
// lands in the result register once that register is free or being taken.
// One item is accepted per cycle unless rsp stalls; the step logic is one 52-bit add.
// Reset clears the walk state and the valid flags; config returns to 0 and 36.
// A stalled rsp holds the result register; req then fills the input register
// and stalls behind it.
module x86_page_table_walker
(
    input  logic                             clk,
    input  logic                             rst_n,
    ptw_req_if.sink                          req,
    ptw_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptw_pkg::PA_W-1:0]         cfg_wdata
);

    logic [ptw_pkg::PA_W-1:0]   root_base_reg;
    logic [ptw_pkg::PAB_W-1:0]  phys_bits_reg;

    logic                       item_valid;
    ptw_pkg::req_item_t         item;
    ptw_pkg::rsp_item_t         res;
    logic                       out_free;
    logic                       fire;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    ptw_pkg::rsp_item_t         out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_base_reg <= '0;
            phys_bits_reg <= ptw_pkg::PHYS_BITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptw_pkg::REG_ROOT_BASE: root_base_reg <= cfg_wdata;
                ptw_pkg::REG_PHYS_BITS: phys_bits_reg <= cfg_wdata[ptw_pkg::PAB_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = item_valid && out_free;

    ptw_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    ptw_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item),
        .root_base  (root_base_reg),
        .phys_bits  (phys_bits_reg),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_item_reg.kind;
    assign rsp.address    = out_item_reg.address;
    assign rsp.page_size  = out_item_reg.page_size;
    assign rsp.walk_level = out_item_reg.walk_level;

endmodule

// ===== tb/sv/ptw_walk_checker.sv =====
// Checker for the page-table walker: mirrors the walk, predicts each result and compares.
module ptw_walk_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    ptw_req_if                            req,
    ptw_rsp_if                            rsp,
    input  logic                          cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptw_pkg::PA_W-1:0]      cfg_wdata,
    output int                            mismatches,
    output int                            results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ptw_pkg::PA_W-1:0]  root_base;
    logic [ptw_pkg::PAB_W-1:0] phys_bits;
    logic                      walking;
    logic                      long_walk;
    logic [ptw_pkg::VA_W-1:0]  walk_va;
    logic [1:0]                depth;
    int                        fail_count;
    ptw_pkg::rsp_item_t        walk_results_q[$];

    assign mismatches = fail_count;

    // Bits phys_bits-1 down to 12; widths beyond 52 clamp to 52.
    function automatic logic [ptw_pkg::PA_W-1:0] addr_mask();
        logic [6:0]  bits;
        logic [63:0] m;
        bits = (phys_bits > 6'd52) ? 7'd52 : {1'b0, phys_bits};
        m = ((64'd1 << bits) - 64'd1) & ~64'hFFF;
        return m[ptw_pkg::PA_W-1:0];
    endfunction

    function automatic ptw_pkg::rsp_item_t fault();
        ptw_pkg::rsp_item_t r;
        r.kind = ptw_pkg::KIND_ERROR;
        r.address = '0;
        r.page_size = ptw_pkg::PAGE_4K;
        r.walk_level = 2'd0;
        return r;
    endfunction

    function automatic ptw_pkg::rsp_item_t entry_read(input logic [ptw_pkg::PA_W-1:0] base,
                                                      input logic [ptw_pkg::IDX_W-1:0] idx,
                                                      input logic [1:0] lvl);
        ptw_pkg::rsp_item_t r;
        depth = lvl;
        r.kind = ptw_pkg::KIND_READ;
        r.address = base + {40'd0, idx, 3'b000};
        r.page_size = ptw_pkg::PAGE_4K;
        r.walk_level = lvl;
        return r;
    endfunction

    function automatic ptw_pkg::rsp_item_t page_done(input logic [ptw_pkg::ENTRY_W-1:0] ent,
                                                     input logic [ptw_pkg::PA_W-1:0] off,
                                                     input ptw_pkg::page_t size);
        ptw_pkg::rsp_item_t r;
        walking = 1'b0;
        depth = 2'd0;
        r.kind = ptw_pkg::KIND_DONE;
        r.address = (ent[ptw_pkg::PA_W-1:0] & addr_mask() & ~off) + ({4'd0, walk_va} & off);
        r.page_size = size;
        r.walk_level = 2'd0;
        return r;
    endfunction

    function automatic ptw_pkg::rsp_item_t walk_step(input logic act, input logic mode,
                                                     input logic [ptw_pkg::VA_W-1:0] va,
                                                     input logic [ptw_pkg::ENTRY_W-1:0] ent);
        logic [ptw_pkg::PA_W-1:0] base;
        base = ent[ptw_pkg::PA_W-1:0] & addr_mask();
        if (act == ptw_pkg::ACT_REQUEST)
        begin
            // a request in the middle of a walk aborts it
            if (walking)
            begin
                walking = 1'b0;
                depth = 2'd0;
                return fault();
            end
            walking = 1'b1;
            long_walk = mode;
            if (mode)
            begin
                walk_va = va;
                return entry_read(root_base & addr_mask(), walk_va[47:39], 2'd0);
            end
            walk_va = {16'd0, va[31:0]};
            return entry_read(root_base & ptw_pkg::PAE_ROOT_MASK, {7'd0, walk_va[31:30]},
                              2'd0);
        end
        if (!walking)
            return fault();
        if (long_walk)
        begin
            case (depth)
                2'd0: return entry_read(base, walk_va[38:30], 2'd1);
                2'd1:
                begin
                    if (ent[ptw_pkg::LARGE_BIT])
                        return page_done(ent, ptw_pkg::OFF_1G, ptw_pkg::PAGE_1G);
                    return entry_read(base, walk_va[29:21], 2'd2);
                end
                2'd2:
                begin
                    if (ent[ptw_pkg::LARGE_BIT])
                        return page_done(ent, ptw_pkg::OFF_2M, ptw_pkg::PAGE_2M);
                    return entry_read(base, walk_va[20:12], 2'd3);
                end
                default: return page_done(ent, ptw_pkg::OFF_4K, ptw_pkg::PAGE_4K);
            endcase
        end
        case (depth)
            2'd0: return entry_read(base, walk_va[29:21], 2'd1);
            2'd1:
            begin
                if (ent[ptw_pkg::LARGE_BIT])
                    return page_done(ent, ptw_pkg::OFF_2M, ptw_pkg::PAGE_2M);
                return entry_read(base, walk_va[20:12], 2'd2);
            end
            default: return page_done(ent, ptw_pkg::OFF_4K, ptw_pkg::PAGE_4K);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ptw_pkg::rsp_item_t got;
        ptw_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            root_base = '0;
            phys_bits = ptw_pkg::PHYS_BITS_RESET;
            walking = 1'b0;
            long_walk = 1'b0;
            walk_va = '0;
            depth = 2'd0;
            fail_count = 0;
            walk_results_q.delete();
            results_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ptw_pkg::REG_ROOT_BASE)
                    root_base = cfg_wdata;
                else if (cfg_index == ptw_pkg::REG_PHYS_BITS)
                    phys_bits = cfg_wdata[ptw_pkg::PAB_W-1:0];
            end
            if (rsp.valid && rsp.ready)
            begin
                got.kind = rsp.kind;
                got.address = rsp.address;
                got.page_size = rsp.page_size;
                got.walk_level = rsp.walk_level;
                if (walk_results_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected walk result kind=%0d addr=%h size=%0d level=%0d",
                             $time, got.kind, got.address, got.page_size, got.walk_level);
                end
                else
                begin
                    want = walk_results_q.pop_front();
                    if (got.kind !== want.kind || got.address !== want.address ||
                        got.page_size !== want.page_size ||
                        got.walk_level !== want.walk_level)
                    begin
                        fail_count++;
                        $display("%0t: walk result mismatch: expected kind=%0d addr=%h ",
                                 $time, want.kind, want.address,
                                 "size=%0d level=%0d, ", want.page_size, want.walk_level,
                                 "got kind=%0d addr=%h size=%0d level=%0d",
                                 got.kind, got.address, got.page_size, got.walk_level);
                    end
                end
            end
            if (req.valid && req.ready)
                walk_results_q.push_back(walk_step(req.action, req.long_mode,
                                                   req.vaddr, req.entry_data));
            results_pending <= walk_results_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_x86_page_table_walker.sv =====
// Stimulus and verdict for the page-table walker: directed walks, then random walks with noise.
module tb_x86_page_table_walker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ptw_pkg::PA_W-1:0]      cfg_wdata;
    int                            src_idle_pct;
    int                            sink_stall_pct;
    int                            cycles;
    int                            mismatches;
    int                            results_pending;
    logic                          walk_busy;
    logic                          walk_long;
    logic [1:0]                    walk_depth;

    ptw_req_if req_ch();
    ptw_rsp_if rsp_ch();

    x86_page_table_walker u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ptw_walk_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [ptw_pkg::VA_W-1:0] rand_va();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ptw_pkg::VA_W-1:0];
    endfunction

    function automatic logic [ptw_pkg::ENTRY_W-1:0] rand_entry(input logic page_bit);
        logic [ptw_pkg::ENTRY_W-1:0] e;
        e = {$urandom, $urandom};
        e[ptw_pkg::LARGE_BIT] = page_bit;
        return e;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic act, input logic mode,
                             input logic [ptw_pkg::VA_W-1:0] va,
                             input logic [ptw_pkg::ENTRY_W-1:0] ent);
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.action = act;
        req_ch.long_mode = mode;
        req_ch.vaddr = va;
        req_ch.entry_data = ent;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        req_ch.valid = 1'b0;
        // follow the walk depth so random stimulus can carry walks to the end
        if (act == ptw_pkg::ACT_REQUEST)
        begin
            if (walk_busy)
                walk_busy = 1'b0;
            else
            begin
                walk_busy = 1'b1;
                walk_long = mode;
                walk_depth = 2'd0;
            end
        end
        else if (walk_busy)
        begin
            if (walk_depth == 2'd0)
                walk_depth = 2'd1;
            else if (walk_depth == (walk_long ? 2'd3 : 2'd2) || ent[ptw_pkg::LARGE_BIT])
                walk_busy = 1'b0;
            else
                walk_depth++;
        end
    endtask

    // Full walk; the entry at depth large_at carries the large-page bit.
    task automatic walk(input logic mode, input logic [ptw_pkg::VA_W-1:0] va,
                        input int large_at);
        send_item(ptw_pkg::ACT_REQUEST, mode, va, rand_entry(1'b0));
        while (walk_busy)
            send_item(ptw_pkg::ACT_ENTRY, 1'($urandom_range(1)), rand_va(),
                      rand_entry(walk_depth == large_at));
    endtask

    task automatic drain();
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [ptw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptw_pkg::PA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_item();
        if ($urandom_range(99) < 12)
            send_item(1'($urandom_range(1)), 1'($urandom_range(1)), rand_va(),
                      rand_entry(1'($urandom_range(1))));
        else if (!walk_busy)
            send_item(ptw_pkg::ACT_REQUEST, 1'($urandom_range(1)), rand_va(),
                      rand_entry(1'b0));
        else
            send_item(ptw_pkg::ACT_ENTRY, 1'($urandom_range(1)), rand_va(),
                      rand_entry($urandom_range(99) < 30));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ptw_pkg::REG_ROOT_BASE;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.action = ptw_pkg::ACT_REQUEST;
        req_ch.long_mode = 1'b0;
        req_ch.vaddr = '0;
        req_ch.entry_data = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        walk_busy = 1'b0;
        walk_long = 1'b0;
        walk_depth = 2'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // wide physical width and an all-ones root
        write_reg(ptw_pkg::REG_PHYS_BITS, 52'd63);
        write_reg(ptw_pkg::REG_ROOT_BASE, {ptw_pkg::PA_W{1'b1}});
        send_item(ptw_pkg::ACT_ENTRY, 1'b1, {ptw_pkg::VA_W{1'b1}}, {ptw_pkg::ENTRY_W{1'b1}});
        send_item(ptw_pkg::ACT_REQUEST, 1'b1, '0, '0);
        repeat (4) send_item(ptw_pkg::ACT_ENTRY, 1'b1, '0, '0);
        send_item(ptw_pkg::ACT_REQUEST, 1'b1, {ptw_pkg::VA_W{1'b1}}, {ptw_pkg::ENTRY_W{1'b1}});
        repeat (2) send_item(ptw_pkg::ACT_ENTRY, 1'b0, {ptw_pkg::VA_W{1'b1}},
                             {ptw_pkg::ENTRY_W{1'b1}});

        // empty mask, PAE walks with upper address bits set
        drain();
        write_reg(ptw_pkg::REG_PHYS_BITS, 52'd0);
        walk(1'b0, {ptw_pkg::VA_W{1'b1}}, 1);
        walk(1'b0, rand_va(), 0);

        // narrowest nonempty mask, 2M long-mode walk, abort, stray entry
        drain();
        write_reg(ptw_pkg::REG_PHYS_BITS, 52'd13);
        write_reg(ptw_pkg::REG_ROOT_BASE, 52'({$urandom, $urandom}));
        walk(1'b1, rand_va(), 2);
        send_item(ptw_pkg::ACT_REQUEST, 1'b1, rand_va(), rand_entry(1'b1));
        send_item(ptw_pkg::ACT_REQUEST, 1'b0, rand_va(), rand_entry(1'b0));
        send_item(ptw_pkg::ACT_ENTRY, 1'b1, rand_va(), rand_entry(1'b1));

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    write_reg(ptw_pkg::REG_PHYS_BITS, 52'(ptw_pkg::PHYS_BITS_RESET));
                    write_reg(ptw_pkg::REG_ROOT_BASE, 52'({$urandom, $urandom}));
                end
                1:
                begin
                    src_idle_pct = 50;
                    sink_stall_pct = 0;
                    write_reg(ptw_pkg::REG_PHYS_BITS, 52'd52);
                    write_reg(ptw_pkg::REG_ROOT_BASE, {ptw_pkg::PA_W{1'b1}});
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 50;
                    write_reg(ptw_pkg::REG_PHYS_BITS, 52'd32);
                    write_reg(ptw_pkg::REG_ROOT_BASE, '0);
                end
                default:
                begin
                    src_idle_pct = 34;
                    sink_stall_pct = 34;
                    write_reg(ptw_pkg::REG_PHYS_BITS, 52'($urandom_range(52, 32)));
                    write_reg(ptw_pkg::REG_ROOT_BASE, 52'({$urandom, $urandom}));
                end
            endcase
            repeat (PHASE_ITEMS) random_item();
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        while (results_pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
